@@ rtl/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// Radiotap TX rate parser package
// Shared types, field tables and decode helpers for the header parser.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int unsigned MaxPresentWords = 8;
  localparam int unsigned KnownFields     = 24;
  localparam int unsigned NumWalkBits     = 31;
  localparam int unsigned NumCapture      = 5;
  localparam int unsigned MinHdrLen       = 8;

  localparam logic [4:0] BitRate    = 5'd2;
  localparam logic [4:0] BitTxFlags = 5'd15;
  localparam logic [4:0] BitMcs     = 5'd19;
  localparam logic [4:0] BitVht     = 5'd21;

  typedef enum logic [1:0] {
    PH_FIXED,
    PH_PRESENT,
    PH_FIELD,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD       = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PHY_CCK  = 2'd0,
    PHY_OFDM = 2'd1,
    PHY_HT   = 2'd2,
    PHY_VHT  = 2'd3
  } phy_e;

  typedef struct packed {
    phy_e       phy;
    logic [7:0] rate;
    logic [5:0] nss;
    logic [1:0] bw;
    logic       sgi;
    logic       ldpc;
    logic       stbc;
    logic       noack;
  } rate_t;

  localparam rate_t RateDefault = '{
    phy:   PHY_OFDM,
    rate:  8'd0,
    nss:   6'd1,
    bw:    2'd0,
    sgi:   1'b0,
    ldpc:  1'b0,
    stbc:  1'b0,
    noack: 1'b0
  };

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] flen;
    logic        last;
  } in_t;

  typedef struct packed {
    logic        done;
    status_e     status;
    logic [4:0]  idx;
    logic [15:0] fend;
  } walk_t;

  typedef logic [NumCapture-1:0][7:0] cap_t;

  function automatic logic [3:0] fld_size(input logic [4:0] b);
    logic [3:0] s;
    case (b)
      5'd0, 5'd20:                                  s = 4'd8;
      5'd3:                                         s = 4'd4;
      5'd19:                                        s = 4'd3;
      5'd21, 5'd22, 5'd23:                          s = 4'd12;
      5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15:         s = 4'd2;
      5'd1, 5'd2, 5'd5, 5'd6, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd16, 5'd17:                          s = 4'd1;
      default:                                      s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] fld_align(input logic [4:0] b);
    logic [3:0] a;
    case (b)
      5'd0, 5'd22:                                  a = 4'd8;
      5'd20:                                        a = 4'd4;
      5'd3, 5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15,
      5'd21, 5'd23:                                 a = 4'd2;
      default:                                      a = 4'd1;
    endcase
    return a;
  endfunction

  // {hit, cck, index}
  function automatic logic [4:0] legacy_lookup(input logic [7:0] code);
    logic [4:0] r;
    case (code)
      8'd2:    r = {2'b11, 3'd0};
      8'd4:    r = {2'b11, 3'd1};
      8'd11:   r = {2'b11, 3'd2};
      8'd22:   r = {2'b11, 3'd3};
      8'd12:   r = {2'b10, 3'd0};
      8'd18:   r = {2'b10, 3'd1};
      8'd24:   r = {2'b10, 3'd2};
      8'd36:   r = {2'b10, 3'd3};
      8'd48:   r = {2'b10, 3'd4};
      8'd72:   r = {2'b10, 3'd5};
      8'd96:   r = {2'b10, 3'd6};
      8'd108:  r = {2'b10, 3'd7};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] vht_bw_map(input logic [7:0] code);
    logic [1:0] bw;
    case (code)
      8'd1, 8'd5, 8'd6: bw = 2'd1;
      8'd4:             bw = 2'd2;
      default:          bw = 2'd0;
    endcase
    return bw;
  endfunction

endpackage

@@ rtl/rtp_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte transaction until the parse stage takes it.
// ----------------------------------------------------------------------------
module rtp_in_reg import rtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic pop_i,
  output in_t  data_o
);

  logic vld_q;
  in_t  data_q;

  assign ready_o = !vld_q || pop_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

@@ rtl/rtp_walk.sv @@
// ----------------------------------------------------------------------------
// Present bit walker
// Finds the next present field, aligns it and checks it against the header.
// ----------------------------------------------------------------------------
module rtp_walk import rtp_pkg::*; (
  input  logic [NumWalkBits-1:0] present_i,
  input  logic [4:0]             b0_i,
  input  logic [16:0]            off_i,
  input  logic [15:0]            hdr_len_i,
  output walk_t                  res_o
);

  logic        hit;
  logic [4:0]  idx;
  logic [3:0]  size;
  logic [17:0] amask;
  logic [17:0] start;
  logic [17:0] fend;

  always_comb begin
    hit = 1'b0;
    idx = 5'd0;
    for (int b = NumWalkBits - 1; b >= 0; b--) begin
      if (present_i[b] && (5'(b) >= b0_i)) begin
        hit = 1'b1;
        idx = 5'(b);
      end
    end
  end

  assign size  = fld_size(idx);
  assign amask = {14'd0, fld_align(idx) - 4'd1};
  assign start = ({1'b0, off_i} + amask) & ~amask;
  assign fend  = start + {14'd0, size};

  always_comb begin
    res_o.done   = 1'b0;
    res_o.status = ST_OK;
    res_o.idx    = idx;
    res_o.fend   = fend[15:0];
    if (!hit || (idx >= 5'(KnownFields)) || (size == 4'd0)) begin
      res_o.done = 1'b1;
    end else if (fend > {2'b00, hdr_len_i}) begin
      res_o.done   = 1'b1;
      res_o.status = ST_MALFORMED;
    end
  end

endmodule

@@ rtl/rtp_decode.sv @@
// ----------------------------------------------------------------------------
// Rate field decoder
// Updates the rate word from the bytes captured for a finished field.
// ----------------------------------------------------------------------------
module rtp_decode import rtp_pkg::*; (
  input  logic [4:0] idx_i,
  input  cap_t       cap_i,
  input  logic       mcs_present_i,
  input  rate_t      rate_i,
  output rate_t      rate_o
);

  logic [4:0] leg;

  assign leg = legacy_lookup(cap_i[0]);

  always_comb begin
    rate_o = rate_i;
    case (idx_i)
      BitRate: begin
        if (!mcs_present_i) begin
          rate_o.phy  = PHY_OFDM;
          rate_o.rate = 8'd0;
          if (leg[4]) begin
            rate_o.phy  = leg[3] ? PHY_CCK : PHY_OFDM;
            rate_o.rate = {5'd0, leg[2:0]};
          end
        end
      end
      BitTxFlags: begin
        if (cap_i[0][3]) begin
          rate_o.noack = 1'b1;
        end
      end
      BitMcs: begin
        rate_o.phy  = PHY_HT;
        rate_o.rate = cap_i[2];
        rate_o.nss  = 6'd1 + {1'b0, cap_i[2][7:3]};
        if (cap_i[0][0] && (cap_i[1][1:0] == 2'd1)) begin
          rate_o.bw = 2'd1;
        end
        if (cap_i[0][2]) begin
          rate_o.sgi = cap_i[1][2];
        end
        if (cap_i[0][4]) begin
          rate_o.ldpc = cap_i[1][4];
        end
        if (cap_i[0][5]) begin
          rate_o.stbc = |cap_i[1][6:5];
        end
      end
      BitVht: begin
        rate_o.phy  = PHY_VHT;
        rate_o.rate = {4'd0, cap_i[4][7:4]};
        rate_o.nss  = (cap_i[4][3:0] == 4'd0) ? 6'd1 : {2'b00, cap_i[4][3:0]};
        if (cap_i[0][2]) begin
          rate_o.stbc = cap_i[2][0];
        end
        if (cap_i[2][2]) begin
          rate_o.sgi = 1'b1;
        end
        if (cap_i[1][0]) begin
          rate_o.ldpc = 1'b1;
        end
        rate_o.bw = vht_bw_map(cap_i[3]);
      end
      default: begin
        rate_o = rate_i;
      end
    endcase
  end

endmodule

@@ rtl/radiotap_tx_rate_parser.sv @@
// ----------------------------------------------------------------------------
// Radiotap TX rate parser
// Parses a radiotap header byte by byte and reports the requested TX rate.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  in      | in_valid_i / in_ready_o | data_byte_i, frame_len_i, last_byte_i
//  out     | out_valid_o/out_ready_i | status_o, header_len_o, rate fields
//
//  One byte per cycle sustained while no result waits; out_valid_o rises once
//  the byte ending parsing has passed the input and result registers.
//  At most one result per frame; the parser returns to the fixed header state
//  after the last byte. Reset clears all but data registers; no clearing pass.
//  A result not taken holds the parse stage; the input register then fills
//  and in_ready_o drops.
// ----------------------------------------------------------------------------
module radiotap_tx_rate_parser import rtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] frame_len_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] header_len_o,
  output logic [1:0]  phy_mode_o,
  output logic [7:0]  rate_index_o,
  output logic [5:0]  stream_count_o,
  output logic [1:0]  bandwidth_o,
  output logic        short_gi_o,
  output logic        ldpc_coding_o,
  output logic        stbc_on_o,
  output logic        no_ack_o
);

  in_t  in_d;
  in_t  cur;
  logic cur_vld;
  logic adv;

  phase_e      phase_q, phase_d;
  logic [15:0] off_q, off_d;
  logic [15:0] hdr_q, hdr_d;
  logic [31:0] pf_q, pf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [4:0]  fi_q, fi_d;
  logic [15:0] fend_q, fend_d;
  cap_t        cap_q, cap_d;
  rate_t       rate_q, rate_d;

  logic        out_vld_q;
  logic [1:0]  out_st_q;
  logic [15:0] out_hdr_q;
  rate_t       out_rate_q;

  logic        emit;
  status_e     emit_st;
  logic [15:0] res_hdr;
  rate_t       res_rate;

  logic [4:0]  walk_b0;
  logic [16:0] walk_off;
  walk_t       wr;
  rate_t       dec_rate;
  logic [15:0] fstart;
  logic [15:0] k;
  logic [15:0] hdr_full;
  logic [4:0]  words_done;
  logic [31:0] pf_cur;
  cap_t        cap_cur;

  assign in_d = '{data: data_byte_i, flen: frame_len_i, last: last_byte_i};
  assign adv  = cur_vld && (!out_vld_q || out_ready_i);

  rtp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_d),
    .valid_o (cur_vld),
    .pop_i   (adv),
    .data_o  (cur)
  );

  assign pf_cur = ((phase_q == PH_PRESENT) && (cnt_q == 4'd0)) ?
                  (pf_q | ({24'd0, cur.data} << {off_q[1:0], 3'b000})) : pf_q;

  assign walk_b0  = (phase_q == PH_FIELD) ? fi_q + 5'd1 : 5'd0;
  assign walk_off = (phase_q == PH_FIELD) ? {1'b0, fend_q} : {1'b0, off_q} + 17'd1;

  rtp_walk u_walk (
    .present_i (pf_cur[NumWalkBits-1:0]),
    .b0_i      (walk_b0),
    .off_i     (walk_off),
    .hdr_len_i (hdr_q),
    .res_o     (wr)
  );

  rtp_decode u_decode (
    .idx_i         (fi_q),
    .cap_i         (cap_cur),
    .mcs_present_i (pf_q[BitMcs]),
    .rate_i        (rate_q),
    .rate_o        (dec_rate)
  );

  assign fstart     = fend_q - {12'd0, fld_size(fi_q)};
  assign k          = off_q - fstart;
  assign hdr_full   = {cur.data, hdr_q[7:0]};
  assign words_done = {1'b0, cnt_q} + 5'd1;

  always_comb begin
    cap_cur = cap_q;
    if ((phase_q == PH_FIELD) && (off_q >= fstart)) begin
      if (k < 16'(NumCapture)) begin
        cap_cur[k[2:0]] = cur.data;
      end else if (k == 16'd8) begin
        cap_cur[1] = cur.data;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    hdr_d   = hdr_q;
    pf_d    = pf_cur;
    cnt_d   = cnt_q;
    fi_d    = fi_q;
    fend_d  = fend_q;
    cap_d   = cap_cur;
    rate_d  = rate_q;
    emit    = 1'b0;
    emit_st = ST_OK;

    case (phase_q)
      PH_FIXED: begin
        if (off_q == 16'd0) begin
          if ((cur.flen < 16'(MinHdrLen)) || (cur.data != 8'd0)) begin
            emit    = 1'b1;
            emit_st = ST_BAD;
          end
        end else if (off_q == 16'd2) begin
          hdr_d = {8'd0, cur.data};
        end else if (off_q == 16'd3) begin
          hdr_d = hdr_full;
          if ((hdr_full < 16'(MinHdrLen)) || (hdr_full > cur.flen)) begin
            emit    = 1'b1;
            emit_st = ST_BAD;
          end else begin
            phase_d = PH_PRESENT;
            cnt_d   = 4'd0;
          end
        end
      end
      PH_PRESENT: begin
        if (off_q[1:0] == 2'd3) begin
          if (cur.data[7]) begin
            if ((words_done >= 5'(MaxPresentWords)) ||
                (({1'b0, off_q} + 17'd5) > {1'b0, hdr_q})) begin
              emit    = 1'b1;
              emit_st = ST_BAD;
            end else begin
              cnt_d = words_done[3:0];
            end
          end else if (wr.done) begin
            emit    = 1'b1;
            emit_st = wr.status;
          end else begin
            phase_d = PH_FIELD;
            fi_d    = wr.idx;
            fend_d  = wr.fend;
          end
        end
      end
      PH_FIELD: begin
        if (off_q >= fstart) begin
          if (({1'b0, off_q} + 17'd1) == {1'b0, fend_q}) begin
            rate_d = dec_rate;
            if (wr.done) begin
              emit    = 1'b1;
              emit_st = wr.status;
            end else begin
              fi_d   = wr.idx;
              fend_d = wr.fend;
            end
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (emit) begin
      phase_d = PH_DONE;
    end
    if (phase_d != PH_DONE) begin
      off_d = off_q + 16'd1;
    end

    if (cur.last && !emit && (phase_q != PH_DONE)) begin
      emit    = 1'b1;
      emit_st = ST_BAD;
    end

    res_hdr  = (emit_st == ST_BAD) ? 16'd0 : hdr_d;
    res_rate = (emit_st == ST_OK) ? rate_d : RateDefault;

    if (cur.last) begin
      phase_d = PH_FIXED;
      off_d   = 16'd0;
      hdr_d   = 16'd0;
      pf_d    = 32'd0;
      cnt_d   = 4'd0;
      fi_d    = 5'd0;
      fend_d  = 16'd0;
      cap_d   = '0;
      rate_d  = RateDefault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIXED;
      off_q   <= 16'd0;
      hdr_q   <= 16'd0;
      pf_q    <= 32'd0;
      cnt_q   <= 4'd0;
      fi_q    <= 5'd0;
      fend_q  <= 16'd0;
      cap_q   <= '0;
      rate_q  <= RateDefault;
    end else if (adv) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      hdr_q   <= hdr_d;
      pf_q    <= pf_d;
      cnt_q   <= cnt_d;
      fi_q    <= fi_d;
      fend_q  <= fend_d;
      cap_q   <= cap_d;
      rate_q  <= rate_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_st_q   <= emit_st;
      out_hdr_q  <= res_hdr;
      out_rate_q <= res_rate;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_st_q;
  assign header_len_o   = out_hdr_q;
  assign phy_mode_o     = out_rate_q.phy;
  assign rate_index_o   = out_rate_q.rate;
  assign stream_count_o = out_rate_q.nss;
  assign bandwidth_o    = out_rate_q.bw;
  assign short_gi_o     = out_rate_q.sgi;
  assign ldpc_coding_o  = out_rate_q.ldpc;
  assign stbc_on_o      = out_rate_q.stbc;
  assign no_ack_o       = out_rate_q.noack;

  a_bad_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_BAD)) |-> (header_len_o == 16'd0))
    else $error("bad header result carries a length");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("result status out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cur.last) |=> ((phase_q == PH_FIXED) && (off_q == 16'd0)))
    else $error("parser did not restart after last byte");

  a_field_in_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIELD) |-> (fend_q <= hdr_q))
    else $error("field end beyond header length");

  a_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((stream_count_o != 6'd0) && (stream_count_o <= 6'd32)))
    else $error("stream count out of range");

endmodule
